### sv/clts_pkg.sv
// shared types, token kinds and scanner mode codes for the token scanner
package clts_pkg;

    localparam int PosWidthDefault   = 24;
    localparam int KeywordMaxDefault = 6;
    localparam int OutPosWidth       = 24;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_INT, M_IDENT, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_STR, M_STR_ESC
    } scan_mode_t;

    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_PLUS     = 6'd1;
    localparam logic [5:0] K_MINUS    = 6'd2;
    localparam logic [5:0] K_STAR     = 6'd3;
    localparam logic [5:0] K_SLASH    = 6'd4;
    localparam logic [5:0] K_PERCENT  = 6'd5;
    localparam logic [5:0] K_BANG     = 6'd7;
    localparam logic [5:0] K_LT       = 6'd9;
    localparam logic [5:0] K_GT       = 6'd11;
    localparam logic [5:0] K_AND      = 6'd13;
    localparam logic [5:0] K_OR       = 6'd15;
    localparam logic [5:0] K_LPAREN   = 6'd16;
    localparam logic [5:0] K_RPAREN   = 6'd17;
    localparam logic [5:0] K_LBRACE   = 6'd18;
    localparam logic [5:0] K_RBRACE   = 6'd19;
    localparam logic [5:0] K_EQ       = 6'd21;
    localparam logic [5:0] K_SEMI     = 6'd22;
    localparam logic [5:0] K_COMMA    = 6'd23;
    localparam logic [5:0] K_CHARLIT  = 6'd24;
    localparam logic [5:0] K_STRLIT   = 6'd25;
    localparam logic [5:0] K_INTLIT   = 6'd26;
    localparam logic [5:0] K_IDENT    = 6'd27;
    localparam logic [5:0] K_KWINT    = 6'd28;
    localparam logic [5:0] K_INVALID  = 6'd36;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_BADCHAR = 2'd1;
    localparam logic [1:0] E_UNTERM  = 2'd2;
    localparam logic [1:0] E_UNEXP   = 2'd3;

    // one classified byte handed from front to back
    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } scan_item_t;

    // one token handed to the output stage
    typedef struct packed {
        logic [5:0]             kind;
        logic [OutPosWidth-1:0] start_pos;
        logic [OutPosWidth-1:0] end_pos;
        logic [1:0]             err;
        logic                   last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] op);
        logic [5:0] k;
        unique case (op)
            8'h21:   k = K_BANG;
            8'h3c:   k = K_LT;
            8'h3e:   k = K_GT;
            8'h26:   k = K_AND;
            8'h7c:   k = K_OR;
            default: k = K_EQ;
        endcase
        return k;
    endfunction

    // keyword text, 8 bytes each, zero padded
    function automatic logic [63:0] kw_word(input logic [2:0] i);
        logic [63:0] w;
        unique case (i)
            3'd0: w = {"int",    40'h0};
            3'd1: w = {"if",     48'h0};
            3'd2: w = {"else",   32'h0};
            3'd3: w = {"while",  24'h0};
            3'd4: w = {"for",    40'h0};
            3'd5: w = {"return", 16'h0};
            3'd6: w = {"char",   32'h0};
            default: w = {"extrn", 24'h0};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] i);
        logic [3:0] n;
        unique case (i)
            3'd0, 3'd4: n = 4'd3;
            3'd1:       n = 4'd2;
            3'd2, 3'd6: n = 4'd4;
            3'd3, 3'd7: n = 4'd5;
            default:    n = 4'd6;
        endcase
        return n;
    endfunction

endpackage

### sv/clts_front.sv
// two-entry queue between the input port and the scanner core
module clts_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  clts_pkg::scan_item_t in_item,
    output logic                q_valid,
    input  logic                q_take,
    output clts_pkg::scan_item_t q_item
);
    import clts_pkg::*;

    scan_item_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_take && q_valid;
    assign q_item   = buf_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop)
        else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count");
`endif
endmodule

### sv/clts_back.sv
// scanner core: mode machine, positions, keyword buffer and token output register
module clts_back #(
    parameter int POS_WIDTH   = clts_pkg::PosWidthDefault,
    parameter int KEYWORD_MAX = clts_pkg::KeywordMaxDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_take,
    input  clts_pkg::scan_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output clts_pkg::token_t     out_tok
);
    import clts_pkg::*;

    localparam int KlW = $clog2(KEYWORD_MAX + 2);
    localparam int KiW = $clog2(KEYWORD_MAX);
    localparam logic [POS_WIDTH-1:0] PosMax = {POS_WIDTH{1'b1}};

    scan_mode_t           mode_reg, mode_next;
    logic [7:0]           op_reg, op_next;
    logic [POS_WIDTH-1:0] ts_reg, ts_next, cp_reg, cp_next;
    logic [7:0]           kb_reg [KEYWORD_MAX];
    logic [KlW-1:0]       kl_reg, kl_next;
    logic                 kb_we;
    logic [KiW-1:0]       kb_idx;

    // output stage: up to two tokens, second one held until the first is taken
    token_t               o0_reg, o1_reg;
    logic                 v0_reg, v1_reg;

    token_t               t_a, t_b;
    logic                 n_a, n_b;
    logic                 can_take;
    logic [5:0]           id_kind;
    logic [7:0]           c;
    logic [POS_WIDTH-1:0] cp1;
    logic [OutPosWidth-1:0] ts_o, cp_o, cp1_o;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] p);
        return (p == PosMax) ? p : p + 1'b1;
    endfunction

    function automatic logic [OutPosWidth-1:0] low_pos(input logic [POS_WIDTH-1:0] p);
        logic [OutPosWidth+POS_WIDTH-1:0] w;
        w = {{OutPosWidth{1'b0}}, p};
        return w[OutPosWidth-1:0];
    endfunction

    // keyword match over the buffered bytes
    always_comb
    begin
        logic hit;
        logic [KlW-1:0] len;
        logic [63:0] word;
        id_kind = K_IDENT;
        for (int i = 0; i < 8; i++)
        begin
            len  = KlW'(kw_len(3'(i)));
            word = kw_word(3'(i));
            hit  = (kl_reg == len);
            for (int j = 0; j < KEYWORD_MAX; j++)
            begin
                if (j < 8 && KlW'(j) < kl_reg)
                begin
                    if (kb_reg[j] != word[63-8*j -: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit && id_kind == K_IDENT)
            begin
                id_kind = K_KWINT + 6'(i);
            end
        end
    end

    assign can_take = !v1_reg && (!v0_reg || !out_stall);
    assign q_take   = can_take;
    assign c        = q_item.char_code;
    assign cp1      = sat_inc(cp_reg);
    assign ts_o     = low_pos(ts_reg);
    assign cp_o     = low_pos(cp_reg);
    assign cp1_o    = low_pos(cp1);

    // idle-mode scan of c with the token starting at position s
    function automatic void idle_scan(
        input  logic [7:0]           ch,
        input  logic [POS_WIDTH-1:0] s,
        output logic                 emit,
        output logic [5:0]           kind,
        output logic [1:0]           err,
        output scan_mode_t           nm
    );
        emit = 1'b1;
        kind = K_INVALID;
        err  = E_NONE;
        nm   = M_IDLE;
        unique case (ch)
            8'h2b: kind = K_PLUS;
            8'h2d: kind = K_MINUS;
            8'h2a: kind = K_STAR;
            8'h2f: kind = K_SLASH;
            8'h25: kind = K_PERCENT;
            8'h28: kind = K_LPAREN;
            8'h29: kind = K_RPAREN;
            8'h7b: kind = K_LBRACE;
            8'h7d: kind = K_RBRACE;
            8'h3b: kind = K_SEMI;
            8'h2c: kind = K_COMMA;
            8'h21, 8'h3c, 8'h3e, 8'h26, 8'h7c, 8'h3d:
            begin
                emit = 1'b0;
                nm   = M_OP;
            end
            8'h27:
            begin
                emit = 1'b0;
                nm   = M_CH_OPEN;
            end
            8'h22:
            begin
                emit = 1'b0;
                nm   = M_STR;
            end
            default:
            begin
                if (is_space(ch))
                begin
                    emit = 1'b0;
                end
                else if (is_digit(ch))
                begin
                    emit = 1'b0;
                    nm   = M_INT;
                end
                else if (is_alpha(ch))
                begin
                    emit = 1'b0;
                    nm   = M_IDENT;
                end
                else
                begin
                    err = E_UNEXP;
                end
            end
        endcase
        if (s == '0)
        begin
            err = err;
        end
    endfunction

    always_comb
    begin
        logic       ie;
        logic [5:0] ik;
        logic [1:0] ier;
        scan_mode_t inm;
        logic       rescan;
        logic [7:0] want;

        mode_next = mode_reg;
        op_next   = op_reg;
        ts_next   = ts_reg;
        cp_next   = cp_reg;
        kl_next   = kl_reg;
        kb_we     = 1'b0;
        kb_idx    = '0;
        n_a       = 1'b0;
        n_b       = 1'b0;
        t_a       = '0;
        t_b       = '0;
        rescan    = 1'b0;
        ie        = 1'b0;
        ik        = K_INVALID;
        ier       = E_NONE;
        inm       = M_IDLE;
        want      = (op_reg == 8'h26 || op_reg == 8'h7c) ? op_reg : 8'h3d;

        if (q_valid && can_take)
        begin
            if (q_item.action)
            begin
                n_a = (mode_reg != M_IDLE);
                t_a.start_pos = ts_o;
                t_a.end_pos   = cp_o;
                unique case (mode_reg)
                    M_OP:    t_a.kind = op_single(op_reg);
                    M_INT:   t_a.kind = K_INTLIT;
                    M_IDENT: t_a.kind = (kl_reg > KlW'(KEYWORD_MAX)) ? K_IDENT : id_kind;
                    M_CH_OPEN, M_CH_ESC, M_CH_CLOSE:
                    begin
                        t_a.kind = K_CHARLIT;
                        t_a.err  = E_BADCHAR;
                    end
                    M_STR, M_STR_ESC:
                    begin
                        t_a.kind = K_STRLIT;
                        t_a.err  = E_UNTERM;
                    end
                    default: t_a.kind = K_EOF;
                endcase
                // eof goes in the first slot when nothing was pending
                if (mode_reg == M_IDLE)
                begin
                    n_a = 1'b1;
                    t_a.start_pos = cp_o;
                    t_a.end_pos   = cp_o;
                end
                else
                begin
                    n_b = 1'b1;
                    t_b.kind      = K_EOF;
                    t_b.start_pos = cp_o;
                    t_b.end_pos   = cp_o;
                end
                mode_next = M_IDLE;
                ts_next   = cp_reg;
            end
            else
            begin
                unique case (mode_reg)
                    M_OP:
                    begin
                        n_a = 1'b1;
                        t_a.start_pos = ts_o;
                        mode_next = M_IDLE;
                        if (c == want)
                        begin
                            cp_next     = cp1;
                            t_a.kind    = op_single(op_reg) - 6'd1;
                            t_a.end_pos = cp1_o;
                        end
                        else
                        begin
                            t_a.kind    = op_single(op_reg);
                            t_a.end_pos = cp_o;
                            rescan      = 1'b1;
                        end
                    end
                    M_INT:
                    begin
                        if (is_digit(c))
                        begin
                            cp_next = cp1;
                        end
                        else
                        begin
                            n_a = 1'b1;
                            t_a.kind = K_INTLIT;
                            t_a.start_pos = ts_o;
                            t_a.end_pos = cp_o;
                            rescan = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (is_digit(c) || is_alpha(c))
                        begin
                            cp_next = cp1;
                            if (kl_reg < KlW'(KEYWORD_MAX))
                            begin
                                kb_we   = 1'b1;
                                kb_idx  = kl_reg[KiW-1:0];
                                kl_next = kl_reg + 1'b1;
                            end
                            else
                            begin
                                kl_next = KlW'(KEYWORD_MAX + 1);
                            end
                        end
                        else
                        begin
                            n_a = 1'b1;
                            t_a.kind = (kl_reg > KlW'(KEYWORD_MAX)) ? K_IDENT : id_kind;
                            t_a.start_pos = ts_o;
                            t_a.end_pos = cp_o;
                            rescan = 1'b1;
                        end
                    end
                    M_CH_OPEN:
                    begin
                        cp_next   = cp1;
                        mode_next = (c == 8'h5c) ? M_CH_ESC : M_CH_CLOSE;
                    end
                    M_CH_ESC:
                    begin
                        cp_next   = cp1;
                        mode_next = M_CH_CLOSE;
                    end
                    M_CH_CLOSE:
                    begin
                        cp_next   = cp1;
                        mode_next = M_IDLE;
                        n_a = 1'b1;
                        t_a.kind = K_CHARLIT;
                        t_a.start_pos = ts_o;
                        t_a.end_pos = cp1_o;
                        t_a.err = (c == 8'h27) ? E_NONE : E_BADCHAR;
                    end
                    M_STR:
                    begin
                        cp_next = cp1;
                        t_a.kind = K_STRLIT;
                        t_a.start_pos = ts_o;
                        t_a.end_pos = cp1_o;
                        if (c == 8'h22)
                        begin
                            mode_next = M_IDLE;
                            n_a = 1'b1;
                        end
                        else if (c == 8'h0a)
                        begin
                            mode_next = M_IDLE;
                            n_a = 1'b1;
                            t_a.err = E_UNTERM;
                        end
                        else if (c == 8'h5c)
                        begin
                            mode_next = M_STR_ESC;
                        end
                    end
                    M_STR_ESC:
                    begin
                        cp_next   = cp1;
                        mode_next = M_STR;
                    end
                    default: rescan = 1'b1;
                endcase

                if (rescan)
                begin
                    idle_scan(c, cp_reg, ie, ik, ier, inm);
                    ts_next   = cp_reg;
                    cp_next   = cp1;
                    mode_next = inm;
                    if (inm == M_OP)
                    begin
                        op_next = c;
                    end
                    if (inm == M_IDENT)
                    begin
                        kb_we   = 1'b1;
                        kb_idx  = '0;
                        kl_next = KlW'(1);
                    end
                    if (ie)
                    begin
                        if (n_a)
                        begin
                            n_b = 1'b1;
                            t_b.kind = ik;
                            t_b.err = ier;
                            t_b.start_pos = cp_o;
                            t_b.end_pos = cp1_o;
                        end
                        else
                        begin
                            n_a = 1'b1;
                            t_a.kind = ik;
                            t_a.err = ier;
                            t_a.start_pos = cp_o;
                            t_a.end_pos = cp1_o;
                        end
                    end
                end
            end
        end
        t_a.last = !n_b;
        t_b.last = 1'b1;
    end

    assign out_valid = v0_reg;
    assign out_tok   = o0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            op_reg   <= '0;
            ts_reg   <= '0;
            cp_reg   <= '0;
            kl_reg   <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            op_reg   <= op_next;
            ts_reg   <= ts_next;
            cp_reg   <= cp_next;
            kl_reg   <= kl_next;
            if (v1_reg)
            begin
                if (!out_stall)
                begin
                    v1_reg <= 1'b0;
                end
            end
            else if (can_take)
            begin
                v0_reg <= n_a;
                v1_reg <= n_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            if (!out_stall)
            begin
                o0_reg <= o1_reg;
            end
        end
        else if (can_take)
        begin
            o0_reg <= t_a;
            o1_reg <= t_b;
        end
        if (kb_we)
        begin
            kb_reg[kb_idx] <= c;
        end
    end

`ifndef SYNTHESIS
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg)
        else $error("second token without first");
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg && out_stall |=> v0_reg && $stable(o0_reg))
        else $error("token dropped under stall");
    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cp_reg >= $past(cp_reg))
        else $error("position went backward");
    a_kl_range: assert property (@(posedge clk) disable iff (!rst_n)
        kl_reg <= KlW'(KEYWORD_MAX + 1))
        else $error("keyword length out of range");
`endif
endmodule

### sv/c_like_token_scanner_top.sv
// top level of the streaming token scanner: input queue plus scanner core
// path: a byte is registered in the queue, scanned from there by the core, its token registered
// throughput: one item per cycle while the output is not stalled; an item giving two tokens holds the core
// the hold comes from the single-token output port draining the second token
// reset: rst_n asynchronous active low clears the mode, positions, queue and output valid
// the keyword buffer has no reset; only bytes written since the identifier began are read
module c_like_token_scanner_top #(
    parameter int POS_WIDTH   = clts_pkg::PosWidthDefault,
    parameter int KEYWORD_MAX = clts_pkg::KeywordMaxDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [23:0] start_pos,
    output logic [23:0] end_pos,
    output logic [1:0]  error_code,
    output logic        last
);
    import clts_pkg::*;

    scan_item_t in_item, q_item;
    token_t     tok;
    logic       q_valid, q_take;

    // front part: registered two-entry queue so the core may stall independently
    assign in_item.action    = action;
    assign in_item.char_code = char_code;

    clts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    // back part: scan mode machine and token output register
    clts_back #(
        .POS_WIDTH   (POS_WIDTH),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tok   (tok)
    );

    assign token_kind = tok.kind;
    assign start_pos  = tok.start_pos;
    assign end_pos    = tok.end_pos;
    assign error_code = tok.err;
    assign last       = tok.last;

`ifndef SYNTHESIS
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last)
        else $error("eof not marked last");
    a_start_le_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && POS_WIDTH <= 24 |-> start_pos <= end_pos)
        else $error("token start after end");
    a_unexpected_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == E_UNEXP |-> token_kind == K_INVALID)
        else $error("unexpected-char error on wrong kind");
`endif
endmodule

### test/tb_c_like_token_scanner_top.sv
// self-checking testbench for the streaming token scanner top level
`timescale 1ns / 1ps

module tb_c_like_token_scanner_top;
    import clts_pkg::*;

    localparam int PosBits = 24;
    localparam logic [PosBits-1:0] PosLimit = '1;

    // token as seen on the output port
    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start_pos;
        logic [23:0] end_pos;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    // one source item: byte or end-of-input mark
    typedef struct packed {
        logic       is_end;
        logic [7:0] byte_val;
    } src_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  token_kind;
    logic [23:0] start_pos;
    logic [23:0] end_pos;
    logic [1:0]  error_code;
    logic        last;

    c_like_token_scanner_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .char_code(char_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .start_pos(start_pos), .end_pos(end_pos),
        .error_code(error_code), .last(last)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // scanner predictor state, own copy
    // ------------------------------------------------------------------
    scan_mode_t         lex_mode;
    logic [7:0]         lex_op;
    logic [PosBits-1:0] lex_start;
    logic [PosBits-1:0] lex_pos;
    logic [7:0]         lex_word [0:5];
    int                 lex_wlen;

    tok_t  expected_tokens [$];
    tok_t  step_toks [$];
    src_t  pending_items [$];
    int    fail_count;
    int    tokens_seen;
    int    items_sent;
    bit    stim_done;

    function automatic logic dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alp(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [5:0] lone_op_kind(input logic [7:0] op);
        case (op)
            "!":     return K_BANG;
            "<":     return K_LT;
            ">":     return K_GT;
            "&":     return K_AND;
            "|":     return K_OR;
            default: return K_EQ;
        endcase
    endfunction

    task automatic push_tok(input logic [5:0] k, input logic [1:0] e);
        tok_t t;
        t.kind = k;
        t.start_pos = lex_start;
        t.end_pos = lex_pos;
        t.err = e;
        t.last = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic bump_pos();
        if (lex_pos != PosLimit)
            lex_pos = lex_pos + 1'b1;
    endtask

    // keyword lookup over the buffered identifier bytes
    function automatic logic [5:0] word_kind();
        string kws [8];
        string w;
        kws = '{"int", "if", "else", "while", "for", "return", "char", "extrn"};
        if (lex_wlen == 0 || lex_wlen > 6)
            return K_IDENT;
        w = "";
        for (int i = 0; i < lex_wlen; i++)
            w = {w, string'(lex_word[i])};
        for (int i = 0; i < 8; i++)
            if (w == kws[i])
                return K_KWINT + 6'(i);
        return K_IDENT;
    endfunction

    task automatic scan_from_idle(input logic [7:0] c);
        logic [5:0] k;
        lex_start = lex_pos;
        bump_pos();
        k = K_INVALID;
        case (c)
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            "%": k = K_PERCENT;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            default: k = K_INVALID;
        endcase
        if (k != K_INVALID)
        begin
            push_tok(k, E_NONE);
        end
        else if (c == "!" || c == "<" || c == ">" || c == "&" || c == "|" || c == "=")
        begin
            lex_op = c;
            lex_mode = M_OP;
        end
        else if (c == "'")
            lex_mode = M_CH_OPEN;
        else if (c == "\"")
            lex_mode = M_STR;
        else if (c == " " || (c >= 8'd9 && c <= 8'd13))
            ;
        else if (dig(c))
            lex_mode = M_INT;
        else if (alp(c))
        begin
            lex_word[0] = c;
            lex_wlen = 1;
            lex_mode = M_IDENT;
        end
        else
            push_tok(K_INVALID, E_UNEXP);
    endtask

    task automatic scan_one_byte(input logic [7:0] c);
        logic [7:0] want;
        case (lex_mode)
            M_OP:
            begin
                want = (lex_op == "&" || lex_op == "|") ? lex_op : 8'("=");
                lex_mode = M_IDLE;
                if (c == want)
                begin
                    bump_pos();
                    push_tok(lone_op_kind(lex_op) - 6'd1, E_NONE);
                end
                else
                begin
                    push_tok(lone_op_kind(lex_op), E_NONE);
                    scan_from_idle(c);
                end
            end
            M_INT:
                if (dig(c))
                    bump_pos();
                else
                begin
                    lex_mode = M_IDLE;
                    push_tok(K_INTLIT, E_NONE);
                    scan_from_idle(c);
                end
            M_IDENT:
                if (alp(c) || dig(c))
                begin
                    bump_pos();
                    if (lex_wlen < 6)
                    begin
                        lex_word[lex_wlen] = c;
                        lex_wlen++;
                    end
                    else
                        lex_wlen = 7;
                end
                else
                begin
                    lex_mode = M_IDLE;
                    push_tok(word_kind(), E_NONE);
                    scan_from_idle(c);
                end
            M_CH_OPEN:
            begin
                bump_pos();
                lex_mode = (c == "\\") ? M_CH_ESC : M_CH_CLOSE;
            end
            M_CH_ESC:
            begin
                bump_pos();
                lex_mode = M_CH_CLOSE;
            end
            M_CH_CLOSE:
            begin
                bump_pos();
                lex_mode = M_IDLE;
                push_tok(K_CHARLIT, (c == "'") ? E_NONE : E_BADCHAR);
            end
            M_STR:
            begin
                bump_pos();
                if (c == "\"")
                begin
                    lex_mode = M_IDLE;
                    push_tok(K_STRLIT, E_NONE);
                end
                else if (c == "\n")
                begin
                    lex_mode = M_IDLE;
                    push_tok(K_STRLIT, E_UNTERM);
                end
                else if (c == "\\")
                    lex_mode = M_STR_ESC;
            end
            M_STR_ESC:
            begin
                bump_pos();
                lex_mode = M_STR;
            end
            default:
            begin
                lex_mode = M_IDLE;
                scan_from_idle(c);
            end
        endcase
    endtask

    task automatic scan_end_mark();
        case (lex_mode)
            M_OP:                          push_tok(lone_op_kind(lex_op), E_NONE);
            M_INT:                         push_tok(K_INTLIT, E_NONE);
            M_IDENT:                       push_tok(word_kind(), E_NONE);
            M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: push_tok(K_CHARLIT, E_BADCHAR);
            M_STR, M_STR_ESC:              push_tok(K_STRLIT, E_UNTERM);
            default: ;
        endcase
        lex_mode = M_IDLE;
        lex_start = lex_pos;
        push_tok(K_EOF, E_NONE);
    endtask

    // run one accepted item through the predictor, queue its tokens
    task automatic predict_tokens(input src_t it);
        step_toks.delete();
        if (it.is_end)
            scan_end_mark();
        else
            scan_one_byte(it.byte_val);
        if (step_toks.size() > 0)
            step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i])
            expected_tokens.push_back(step_toks[i]);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        pending_items.push_back('{is_end: 1'b0, byte_val: b});
    endtask

    task automatic add_end();
        pending_items.push_back('{is_end: 1'b1, byte_val: 8'($urandom_range(0, 255))});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // a well-formed-ish fragment with random content
    task automatic add_fragment();
        string kws [8];
        string ops [16];
        kws = '{"int", "if", "else", "while", "for", "return", "char", "extrn"};
        ops = '{"+", "-", "*", "/", "%", "!=", "!", "<=", "<", ">=", ">", "&&", "&",
                "||", "|", "=="};
        case ($urandom_range(0, 11))
            0, 1: add_text(kws[$urandom_range(0, 7)]);
            2:
            begin
                // identifier, sometimes longer than the keyword buffer
                add_byte(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                  : $urandom_range("A", "Z")));
                repeat ($urandom_range(0, 9))
                    add_byte(8'($urandom_range(0, 2) == 0 ? $urandom_range("0", "9")
                                                          : $urandom_range("a", "z")));
            end
            3: repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range("0", "9")));
            4: add_text(ops[$urandom_range(0, 15)]);
            5: add_text($urandom_range(0, 1) ? "=" : ";");
            6:
            begin
                add_byte("'");
                if ($urandom_range(0, 2) == 0)
                    add_byte("\\");
                add_byte(8'($urandom_range(0, 255)));
                add_byte($urandom_range(0, 4) ? 8'("'") : 8'($urandom_range(0, 255)));
            end
            7:
            begin
                add_byte("\"");
                repeat ($urandom_range(0, 6))
                    add_byte($urandom_range(0, 5) == 0 ? 8'("\\")
                                                       : 8'($urandom_range(32, 126)));
                add_byte($urandom_range(0, 5) ? 8'("\"") : 8'("\n"));
            end
            8: add_text(" ");
            9: add_byte(8'($urandom_range(0, 1) ? "\n" : $urandom_range(9, 13)));
            10: add_byte(8'($urandom_range(0, 255)));
            default: add_text($urandom_range(0, 1) ? "(" : "}");
        endcase
    endtask

    // fill the item queue: directed part then random part
    initial
    begin
        // directed: operators, pairs, literals, special cases
        add_text("+-*/%(){};,");
        add_text("!=!<=<>=>&&&||");
        add_text("|===x");
        add_end();
        add_text("'a''\\n'");
        add_text("'ab");
        add_text("\"s\\\"q\"\"u\n");
        add_byte(8'h80);
        add_byte(8'hff);
        add_byte(8'h00);
        add_text("returnx extrn abcdefgh 09 ");
        add_text("\"cut");
        add_end();
        add_text("'");
        add_end();
        add_end();
        // random part, ends with an end mark so nothing stays pending
        while (pending_items.size() < 950)
        begin
            if ($urandom_range(0, 60) == 0)
                add_end();
            else
                add_fragment();
        end
        add_end();
    end

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            action    <= 1'b0;
            char_code <= 8'd0;
            send_gap  <= 0;
        end
        else
        begin
            // hold the payload while stalled, otherwise move on
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    predict_tokens('{is_end: action, byte_val: char_code});
                    items_sent <= items_sent + 1;
                end
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    src_t it;
                    it = pending_items.pop_front();
                    in_valid  <= 1'b1;
                    action    <= it.is_end;
                    char_code <= it.byte_val;
                    // stretches without gaps now and then
                    send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
                else
                begin
                    in_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and receiver stall
    // ------------------------------------------------------------------
    int recv_gap;
    int hold_cycles;
    int hold_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            recv_gap    <= 0;
            hold_cycles <= 0;
            hold_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                tok_t got;
                tok_t exp_t;
                got = '{kind: token_kind, start_pos: start_pos, end_pos: end_pos,
                        err: error_code, last: last};
                tokens_seen <= tokens_seen + 1;
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: kind %0d", got.kind);
                    fail_count++;
                end
                else
                begin
                    exp_t = expected_tokens.pop_front();
                    if (got.kind != exp_t.kind)
                    begin
                        $error("token_kind: expected %0d actual %0d", exp_t.kind, got.kind);
                        fail_count++;
                    end
                    if (got.start_pos != exp_t.start_pos)
                    begin
                        $error("start_pos: expected %0d actual %0d",
                               exp_t.start_pos, got.start_pos);
                        fail_count++;
                    end
                    if (got.end_pos != exp_t.end_pos)
                    begin
                        $error("end_pos: expected %0d actual %0d", exp_t.end_pos, got.end_pos);
                        fail_count++;
                    end
                    if (got.err != exp_t.err)
                    begin
                        $error("error_code: expected %0d actual %0d", exp_t.err, got.err);
                        fail_count++;
                    end
                    if (got.last != exp_t.last)
                    begin
                        $error("last: expected %0d actual %0d", exp_t.last, got.last);
                        fail_count++;
                    end
                end
            end
            // two long hold-offs while the sender keeps offering items
            if (hold_count < 2 && items_sent > 300 + 300 * hold_count && hold_cycles == 0)
            begin
                hold_cycles <= 60;
                hold_count  <= hold_count + 1;
                out_stall   <= 1'b1;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall   <= (hold_cycles > 1);
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // ------------------------------------------------------------------
    // reset, end of run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = 1'b0;
        char_code   = 8'd0;
        out_stall   = 1'b0;
        fail_count  = 0;
        tokens_seen = 0;
        items_sent  = 0;
        stim_done   = 1'b0;
        lex_mode    = M_IDLE;
        lex_op      = 8'd0;
        lex_start   = '0;
        lex_pos     = '0;
        lex_wlen    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_tokens.size() == 0);
        // keep running to catch any stray token
        repeat (20) @(posedge clk);
        $display("covered %0d items and %0d tokens, incl. literals, keywords and end marks",
                 items_sent, tokens_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
